### design/ps_adpcm_block_decoder_defines.svh
// ----------------------------------------------------------------------------
// PS-ADPCM block decoder assertion macros
// Shared property wrappers; clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PS_ADPCM_BLOCK_DECODER_DEFINES_SVH
`define PS_ADPCM_BLOCK_DECODER_DEFINES_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define PSADPCM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define PSADPCM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/psadpcm_pkg.sv
// ----------------------------------------------------------------------------
// psadpcm_pkg
// Types, constants and coefficient tables of the PS-ADPCM block decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package psadpcm_pkg;

  // Block byte positions
  localparam logic [3:0] POS_SHIFT_FILTER = 4'd0;
  localparam logic [3:0] POS_FLAGS        = 4'd1;
  localparam logic [3:0] POS_LAST         = 4'd15;

  localparam logic [2:0] FILTER_MAX = 3'd4;

  localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

  localparam logic signed [24:0] PRED_ROUND = 25'sd32;
  localparam int unsigned        PRED_FRAC  = 6;

  // One data byte handed from the front to the back
  typedef struct packed {
    logic       clear_hist;  // restart seen since the previous data byte
    logic       last_byte;   // block byte 15
    logic [7:0] data;
    logic [3:0] shift;
    logic [2:0] filter;      // already clamped to 0..4
    logic [7:0] flags;
  } job_t;

  // Queue status seen by the front and the top level
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  // Back-end status for checking
  typedef struct packed {
    logic fire;
    logic phase;
  } back_status_t;

  function automatic logic signed [7:0] coef_newer(input logic [2:0] f);
    logic signed [7:0] c;
    case (f)
      3'd0:    c = 8'sd0;
      3'd1:    c = 8'sd60;
      3'd2:    c = 8'sd115;
      3'd3:    c = 8'sd98;
      default: c = 8'sd122;
    endcase
    return c;
  endfunction

  function automatic logic signed [7:0] coef_older(input logic [2:0] f);
    logic signed [7:0] c;
    case (f)
      3'd0:    c = 8'sd0;
      3'd1:    c = 8'sd0;
      3'd2:    c = -8'sd52;
      3'd3:    c = -8'sd55;
      default: c = -8'sd60;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### design/psadpcm_if.sv
// ----------------------------------------------------------------------------
// psadpcm channel interfaces
// Valid/ready channels for stream bytes in and decoded samples out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface psadpcm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;

  modport source (output valid, output data_byte, output restart, input ready);
  modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface psadpcm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               last_of_pair;
  logic               last_of_block;
  logic               stream_end;
  logic [7:0]         block_flags;

  modport source (output valid, output sample, output last_of_pair,
                  output last_of_block, output stream_end, output block_flags,
                  input ready);
  modport sink   (input valid, input sample, input last_of_pair,
                  input last_of_block, input stream_end, input block_flags,
                  output ready);
endinterface

`default_nettype wire

### design/psadpcm_front.sv
// ----------------------------------------------------------------------------
// psadpcm_front
// Track the block position, latch header fields, queue data bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psadpcm_front (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  psadpcm_in_if.sink                  in_ch,
  input  wire psadpcm_pkg::q_status_t q_status,
  output      logic                   q_push,
  output      psadpcm_pkg::job_t      q_job
);

  logic [3:0] pos_r,    pos_nxt;
  logic [3:0] shift_r,  shift_nxt;
  logic [2:0] filter_r, filter_nxt;
  logic [7:0] flags_r,  flags_nxt;
  logic       pend_clear_r, pend_clear_nxt;

  logic       accept;
  logic [3:0] pos;
  logic [2:0] f_raw;

  assign in_ch.ready = !q_status.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign pos         = in_ch.restart ? psadpcm_pkg::POS_SHIFT_FILTER : pos_r;
  assign f_raw       = in_ch.data_byte[6:4];

  always_comb begin
    pos_nxt        = pos_r;
    shift_nxt      = shift_r;
    filter_nxt     = filter_r;
    flags_nxt      = flags_r;
    pend_clear_nxt = pend_clear_r;
    q_push         = 1'b0;
    if (accept) begin
      pos_nxt = pos + 4'd1;
      if (in_ch.restart) begin
        pend_clear_nxt = 1'b1;
      end
      if (pos == psadpcm_pkg::POS_SHIFT_FILTER) begin
        shift_nxt  = in_ch.data_byte[3:0];
        filter_nxt = (f_raw > psadpcm_pkg::FILTER_MAX) ? psadpcm_pkg::FILTER_MAX : f_raw;
      end else if (pos == psadpcm_pkg::POS_FLAGS) begin
        flags_nxt = in_ch.data_byte;
      end else begin
        q_push         = 1'b1;
        pend_clear_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    q_job.clear_hist = pend_clear_r;
    q_job.last_byte  = (pos == psadpcm_pkg::POS_LAST);
    q_job.data       = in_ch.data_byte;
    q_job.shift      = shift_r;
    q_job.filter     = filter_r;
    q_job.flags      = flags_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      shift_r      <= '0;
      filter_r     <= '0;
      flags_r      <= '0;
      pend_clear_r <= 1'b0;
    end else begin
      pos_r        <= pos_nxt;
      shift_r      <= shift_nxt;
      filter_r     <= filter_nxt;
      flags_r      <= flags_nxt;
      pend_clear_r <= pend_clear_nxt;
    end
  end

endmodule

`default_nettype wire

### design/psadpcm_fifo.sv
// ----------------------------------------------------------------------------
// psadpcm_fifo
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psadpcm_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push,
  input  wire psadpcm_pkg::job_t      push_job,
  input  wire logic                   pop,
  output      psadpcm_pkg::job_t      head_job,
  output      psadpcm_pkg::q_status_t status
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  psadpcm_pkg::job_t mem_r [DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;

  assign status.empty = (count_r == '0);
  assign status.full  = (count_r == CNT_FULL);
  assign head_job     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

### design/psadpcm_back.sv
// ----------------------------------------------------------------------------
// psadpcm_back
// Decode one nibble a cycle if unstalled, vs sample history; register results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psadpcm_back (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire psadpcm_pkg::job_t         job,
  input  wire psadpcm_pkg::q_status_t    q_status,
  output      logic                      q_pop,
  output      psadpcm_pkg::back_status_t status,
  psadpcm_out_if.source                  out_ch
);

  logic phase_r, phase_nxt;
  logic signed [15:0] newer_r, older_r;
  logic out_valid_r, out_valid_nxt;
  logic signed [15:0] sample_r;
  logic pair_r, block_r, end_r;
  logic [7:0] flags_r;

  logic               fire;
  logic               clr;
  logic [3:0]         nib;
  logic signed [15:0] hist_new, hist_old;
  logic signed [15:0] base;
  logic signed [7:0]  c1, c2;
  logic signed [24:0] acc;
  logic signed [18:0] pred;
  logic signed [19:0] sum;
  logic signed [15:0] sat;

  assign fire  = !q_status.empty && (!out_valid_r || out_ch.ready);
  assign q_pop = fire && phase_r;
  assign clr   = job.clear_hist && !phase_r;

  assign status.fire  = fire;
  assign status.phase = phase_r;

  always_comb begin
    nib      = phase_r ? job.data[7:4] : job.data[3:0];
    hist_new = clr ? 16'sd0 : newer_r;
    hist_old = clr ? 16'sd0 : older_r;
    base     = $signed({nib, 12'h000}) >>> job.shift;
    c1       = psadpcm_pkg::coef_newer(job.filter);
    c2       = psadpcm_pkg::coef_older(job.filter);
    acc      = 25'(hist_new) * 25'(c1) + 25'(hist_old) * 25'(c2) + psadpcm_pkg::PRED_ROUND;
    pred     = acc[24:psadpcm_pkg::PRED_FRAC];
    sum      = 20'(base) + 20'(pred);
    if (sum > 20'(psadpcm_pkg::SAMPLE_MAX)) begin
      sat = psadpcm_pkg::SAMPLE_MAX;
    end else if (sum < 20'(psadpcm_pkg::SAMPLE_MIN)) begin
      sat = psadpcm_pkg::SAMPLE_MIN;
    end else begin
      sat = sum[15:0];
    end
  end

  always_comb begin
    phase_nxt     = fire ? !phase_r : phase_r;
    out_valid_nxt = fire || (out_valid_r && !out_ch.ready);
  end

  // Result payload: load on every fired nibble
  always_ff @(posedge clk) begin
    if (fire) begin
      sample_r <= sat;
      pair_r   <= phase_r;
      block_r  <= phase_r && job.last_byte;
      end_r    <= job.flags[0] && !job.flags[1];
      flags_r  <= job.flags;
    end
  end

  // Control and sample history: history starts from zero after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
      newer_r     <= '0;
      older_r     <= '0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        newer_r <= sat;
        older_r <= hist_new;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.sample        = sample_r;
  assign out_ch.last_of_pair  = pair_r;
  assign out_ch.last_of_block = block_r;
  assign out_ch.stream_end    = end_r;
  assign out_ch.block_flags   = flags_r;

endmodule

`default_nettype wire

### design/ps_adpcm_block_decoder.sv
// ----------------------------------------------------------------------------
// ps_adpcm_block_decoder
// PS-ADPCM block decoder: one stream byte in, up to two samples out.
// ----------------------------------------------------------------------------
//
//   channel   dir   word                                              handshake
//   in_ch     in    data_byte[7:0], restart                           valid/ready
//   out_ch    out   sample[15:0], last_of_pair, last_of_block,        valid/ready
//                   stream_end, block_flags[7:0]
//
// Header bytes (block bytes 0 and 1) yield no word.
// The decode unit takes a data byte a nibble at a time: the second prediction
// needs the first sample, so one sample leaves per cycle unless stalled.
// Synchronous active-low reset; no clearing pass, the block is ready the cycle
// after reset drops. The job queue lets the front keep taking bytes while the
// output register waits on out_ch.ready; a full queue drops in_ch.ready.
//
`timescale 1ns / 1ps
`default_nettype none

`include "ps_adpcm_block_decoder_defines.svh"

module ps_adpcm_block_decoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  psadpcm_in_if.sink    in_ch,
  psadpcm_out_if.source out_ch
);

  logic                      q_push;
  logic                      q_pop;
  psadpcm_pkg::job_t         q_in_job;
  psadpcm_pkg::job_t         q_head_job;
  psadpcm_pkg::q_status_t    q_status;
  psadpcm_pkg::back_status_t back_status;

  // Front: count block position, latch shift/filter/flags, queue data bytes
  psadpcm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_status (q_status),
    .q_push   (q_push),
    .q_job    (q_in_job)
  );

  // Queue: hold data bytes with their header context
  psadpcm_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_in_job),
    .pop      (q_pop),
    .head_job (q_head_job),
    .status   (q_status)
  );

  // Back: decode low then high nibble, drive the output register
  psadpcm_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .job      (q_head_job),
    .q_status (q_status),
    .q_pop    (q_pop),
    .status   (back_status),
    .out_ch   (out_ch)
  );

  // The head job stays queued while its high nibble is pending
  `PSADPCM_ASSERT_NOW(a_phase_has_job, back_status.phase, !q_status.empty, "high nibble pending with empty queue")

  // Never push into a full queue
  `PSADPCM_ASSERT_NOW(a_no_push_full, q_push, !q_status.full, "push into full job queue")

  // A fired high nibble returns the decoder to the low nibble
  `PSADPCM_ASSERT_NEXT(a_phase_wrap, back_status.fire && back_status.phase, !back_status.phase, "decode phase did not wrap")

  // End of block only ever marks the second sample of a byte
  `PSADPCM_ASSERT_NOW(a_block_on_pair, out_ch.valid && out_ch.last_of_block, out_ch.last_of_pair, "last_of_block without last_of_pair")

endmodule

`default_nettype wire
